// ===== rtl/rcc_pkg.sv =====
`default_nettype none

package rcc_pkg;

  localparam int unsigned MaxPointsDefault = 512;
  localparam int unsigned IdxW             = 9;
  localparam int unsigned DistW            = 9;
  localparam int unsigned RatioW           = 7;
  localparam int unsigned ProdW            = 16;
  localparam int unsigned InDataW          = 40;
  localparam int unsigned OutDataW         = 32;
  localparam int unsigned ApbAddrW         = 3;
  localparam int unsigned ApbDataW         = 32;
  localparam int unsigned RegIdxRatio      = 0;
  localparam logic [RatioW-1:0] RatioReset = 7'd65;
  localparam logic [ProdW-1:0]  Hundred    = 16'd100;

  typedef enum logic [1:0] {
    KindStore = 2'd0,
    KindCheck = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef struct packed {
    logic             valid;
    logic [IdxW-1:0]  partner;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear_start;
  } tbl_ctrl_t;

  function automatic logic passes_ratio(
    input logic [DistW-1:0]  best,
    input logic [DistW-1:0]  second,
    input logic              has_second,
    input logic [RatioW-1:0] ratio
  );
    logic [ProdW-1:0] lhs;
    logic [ProdW-1:0] rhs;
    lhs = ProdW'(best) * Hundred;
    rhs = ProdW'(ratio) * ProdW'(second);
    return has_second && (lhs <= rhs);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rcc_cfg.sv =====
`default_nettype none

module rcc_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rcc_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [rcc_pkg::ApbDataW-1:0]    pwdata,
  output logic      [rcc_pkg::ApbDataW-1:0]    prdata,
  output logic                                 pready,
  output logic      [rcc_pkg::RatioW-1:0]      ratio_o
);

  logic [rcc_pkg::RatioW-1:0] ratio_q;
  logic [rcc_pkg::RatioW-1:0] ratio_d;
  logic                       sel_ratio;

  assign sel_ratio = (32'(paddr[rcc_pkg::ApbAddrW-1:2]) == rcc_pkg::RegIdxRatio);
  assign pready    = 1'b1;

  always_comb begin
    ratio_d = ratio_q;
    if (psel && penable && pwrite && pready && sel_ratio) begin
      ratio_d = pwdata[rcc_pkg::RatioW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= rcc_pkg::RatioReset;
    end else begin
      ratio_q <= ratio_d;
    end
  end

  assign prdata  = sel_ratio ? rcc_pkg::ApbDataW'(ratio_q) : '0;
  assign ratio_o = ratio_q;

endmodule

`default_nettype wire

// ===== rtl/rcc_table.sv =====
`default_nettype none

module rcc_table #(
  parameter int unsigned MAX_POINTS = rcc_pkg::MaxPointsDefault,
  parameter int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rcc_pkg::tbl_ctrl_t ctrl_i,
  input  wire logic [AW-1:0]      waddr_i,
  input  wire rcc_pkg::entry_t    wdata_i,
  input  wire logic [AW-1:0]      raddr_i,
  output rcc_pkg::entry_t         rdata_o,
  output logic                    busy_o
);

  rcc_pkg::entry_t mem_q [MAX_POINTS];
  rcc_pkg::entry_t rdata_q;
  logic            busy_q;
  logic [AW-1:0]   clr_addr_q;
  logic            we;
  logic [AW-1:0]   wa;
  rcc_pkg::entry_t wd;

  assign we = busy_q || ctrl_i.wr_en;
  assign wa = busy_q ? clr_addr_q : waddr_i;
  assign wd = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // sweep the table after reset and on every clear transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      if (clr_addr_q == AW'(MAX_POINTS - 1)) begin
        busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end else if (ctrl_i.clear_start) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

// ===== rtl/ratio_and_cross_check_filter_core.sv =====
`default_nettype none

// Symmetric ratio-test match filter. A store transfer writes the reverse
// match table in the cycle it is accepted; a check transfer reads the table
// at its best index and its result, if any, is registered in stage s1 and
// then in the output register before it reaches the master side. Stores
// and checks are accepted one per cycle as long as the output is drained.
// The table is a single synchronous memory of MAX_POINTS entries; after
// reset and after each clear transfer it is swept, one entry per cycle,
// during which s_axis_tready is low (configuration writes are still taken).
module ratio_and_cross_check_filter_core #(
  parameter int unsigned MAX_POINTS = rcc_pkg::MaxPointsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: query_index, best_index, best_distance, second_distance,
  //        has_second, zero fill
  input  wire logic [rcc_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: kind
  input  wire logic [1:0]                      s_axis_tuser,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: match_query, match_train, match_distance, zero fill
  output logic      [rcc_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rcc_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [rcc_pkg::ApbDataW-1:0]    pwdata,
  output logic      [rcc_pkg::ApbDataW-1:0]    prdata,
  output logic                                 pready
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned IW = rcc_pkg::IdxW;
  localparam int unsigned DW = rcc_pkg::DistW;

  logic [rcc_pkg::RatioW-1:0] ratio;
  logic [IW-1:0]              in_query;
  logic [IW-1:0]              in_best_idx;
  logic [DW-1:0]              in_best_d;
  logic [DW-1:0]              in_second_d;
  logic                       in_has2;
  rcc_pkg::kind_e             in_kind;
  logic                       in_xfer;
  logic                       in_ok;
  logic                       query_in_range;
  logic                       best_in_range;
  logic                       take_check;

  rcc_pkg::tbl_ctrl_t         tbl_ctrl;
  rcc_pkg::entry_t            tbl_wdata;
  rcc_pkg::entry_t            tbl_rdata;
  logic                       tbl_busy;

  logic                       s1_valid_q, s1_valid_d;
  logic [IW-1:0]              s1_query_q;
  logic [IW-1:0]              s1_train_q;
  logic [DW-1:0]              s1_dist_q;
  logic                       s1_adv;
  logic                       s1_hit;

  logic                       out_valid_q, out_valid_d;
  logic [IW-1:0]              out_query_q;
  logic [IW-1:0]              out_train_q;
  logic [DW-1:0]              out_dist_q;

  assign in_query    = s_axis_tdata[8:0];
  assign in_best_idx = s_axis_tdata[17:9];
  assign in_best_d   = s_axis_tdata[26:18];
  assign in_second_d = s_axis_tdata[35:27];
  assign in_has2     = s_axis_tdata[36];
  assign in_kind     = rcc_pkg::kind_e'(s_axis_tuser);

  rcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ratio_o (ratio)
  );

  assign in_ok          = rcc_pkg::passes_ratio(in_best_d, in_second_d, in_has2, ratio);
  assign query_in_range = (32'(in_query) < MAX_POINTS);
  assign best_in_range  = (32'(in_best_idx) < MAX_POINTS);

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !tbl_busy && (!s1_valid_q || s1_adv);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tbl_ctrl   = '0;
    take_check = 1'b0;
    if (in_xfer) begin
      unique case (in_kind)
        rcc_pkg::KindStore: tbl_ctrl.wr_en = query_in_range;
        rcc_pkg::KindCheck: take_check     = in_ok && best_in_range;
        rcc_pkg::KindClear: tbl_ctrl.clear_start = 1'b1;
        default: ;
      endcase
    end
    tbl_ctrl.rd_en = take_check;
  end

  assign tbl_wdata.valid   = in_ok;
  assign tbl_wdata.partner = in_best_idx;

  rcc_table #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tbl_ctrl),
    .waddr_i (AW'(in_query)),
    .wdata_i (tbl_wdata),
    .raddr_i (AW'(in_best_idx)),
    .rdata_o (tbl_rdata),
    .busy_o  (tbl_busy)
  );

  assign s1_hit = tbl_rdata.valid && (tbl_rdata.partner == s1_query_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take_check) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s1_adv ? (s1_valid_q && s1_hit) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_check) begin
      s1_query_q <= in_query;
      s1_train_q <= in_best_idx;
      s1_dist_q  <= in_best_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_query_q <= s1_query_q;
      out_train_q <= s1_train_q;
      out_dist_q  <= s1_dist_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_dist_q, out_train_q, out_query_q};

`ifndef SYNTHESIS
  a_no_xfer_while_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_busy |-> !s_axis_tready)
    else $error("transfer accepted during table sweep");

  a_clear_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_ctrl.clear_start |=> tbl_busy)
    else $error("clear transfer did not start a sweep");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_query_q)))
    else $error("pending check lost while output stalled");

  a_out_from_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_valid_q))
    else $error("result without a pending check");
`endif

endmodule

`default_nettype wire
